/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the synchronous reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked condition that must never be seen
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

/* src/irclim_pkg.sv */
// ---------------------------------------------------------------------------
// irclim_pkg
// Types, codes, defaults and helper functions of the IR climate transmitter.
// ---------------------------------------------------------------------------
package irclim_pkg;

    localparam int FRAME_BYTES_DEF = 6;
    localparam int REPEATS_DEF     = 2;
    localparam int CORE_BYTES      = 6;

    // Input kinds carried on tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Segment phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HMARK  = 3'd1;
    localparam logic [2:0] PH_HSPACE = 3'd2;
    localparam logic [2:0] PH_BMARK  = 3'd3;
    localparam logic [2:0] PH_BSPACE = 3'd4;
    localparam logic [2:0] PH_FMARK  = 3'd5;
    localparam logic [2:0] PH_GAP    = 3'd6;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_HDR_MARK  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HDR_SPACE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_MARK  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_SPACE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_SPC  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ADDRESS   = 3'd6;

    // Register reset values
    localparam logic [7:0] HDR_MARK_RST  = 8'd56;
    localparam logic [7:0] HDR_SPACE_RST = 8'd56;
    localparam logic [7:0] BIT_MARK_RST  = 8'd7;
    localparam logic [7:0] ONE_SPACE_RST = 8'd21;
    localparam logic [7:0] ZERO_SPC_RST  = 8'd7;
    localparam logic [7:0] GAP_RST       = 8'd70;
    localparam logic [7:0] ADDRESS_RST   = 8'hB2;

    // Frame constants
    localparam logic [4:0] FAN_LOW_RST     = 5'h1F;
    localparam logic [4:0] FAN_LOW_OFF     = 5'h1B;
    localparam logic [7:0] OFF_FAN_BYTE    = 8'h7B;
    localparam logic [7:0] OFF_TEMP_BYTE   = 8'hE0;
    localparam logic [7:0] TEMP_MIN        = 8'd17;
    localparam logic [7:0] TEMP_MAX        = 8'd30;
    localparam logic [7:0] PAD_EVEN_BYTE   = 8'h00;
    localparam logic [7:0] PAD_ODD_BYTE    = 8'hFF;

    localparam logic [3:0] TEMP_CODE_TAB [0:13] = '{
        4'd0, 4'd1, 4'd3, 4'd2, 4'd6, 4'd7, 4'd5,
        4'd4, 4'd12, 4'd13, 4'd9, 4'd8, 4'd10, 4'd11
    };

    typedef struct packed {
        logic       power_on;
        logic [1:0] mode;
        logic [2:0] fan_speed;
        logic [7:0] temperature;
    } t_frame_req;

    typedef struct packed {
        logic ir_on;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_result;

    // Clamp to the supported range and map to the code table
    function automatic logic [3:0] temp_code(input logic [7:0] t);
        logic [7:0] tc;
        logic [3:0] idx;
        tc = t;
        if (tc < TEMP_MIN) tc = TEMP_MIN;
        if (tc > TEMP_MAX) tc = TEMP_MAX;
        idx = 4'(tc - TEMP_MIN);
        return TEMP_CODE_TAB[idx];
    endfunction

    // A programmed length of zero lasts one tick
    function automatic logic [7:0] seg_len(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

/* src/irclim_frame_build.sv */
// ---------------------------------------------------------------------------
// irclim_frame_build
// Assembles the command frame (byte 0 in the top bits) from one send request.
// ---------------------------------------------------------------------------
module irclim_frame_build import irclim_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  t_frame_req                 i_req,
    input  logic [7:0]                 i_address,
    input  logic [4:0]                 i_fan_low,
    output logic [FRAME_BYTES*8-1:0]   o_frame,
    output logic [4:0]                 o_fan_low
);

    logic [7:0] w_core [CORE_BYTES];

    always_comb begin
        w_core[0] = i_address;
        if (i_req.power_on) begin
            w_core[2] = {i_req.fan_speed, i_fan_low};
            w_core[4] = {temp_code(i_req.temperature), i_req.mode, 2'b00};
            o_fan_low = i_fan_low;
        end else begin
            w_core[2] = OFF_FAN_BYTE;
            w_core[4] = OFF_TEMP_BYTE;
            o_fan_low = FAN_LOW_OFF;
        end
        w_core[1] = ~w_core[0];
        w_core[3] = ~w_core[2];
        w_core[5] = ~w_core[4];
    end

    for (genvar gi = 0; gi < FRAME_BYTES; gi++) begin : g_byte
        if (gi < CORE_BYTES) begin : g_core
            assign o_frame[(FRAME_BYTES-1-gi)*8 +: 8] = w_core[gi];
        end else begin : g_pad
            assign o_frame[(FRAME_BYTES-1-gi)*8 +: 8] =
                (gi % 2 == 1) ? PAD_ODD_BYTE : PAD_EVEN_BYTE;
        end
    end

endmodule

/* src/ir_climate_frame_transmitter_core.sv */
// ---------------------------------------------------------------------------
// ir_climate_frame_transmitter_core
// Pulse-distance IR climate command transmitter, one tick per input transfer.
// ---------------------------------------------------------------------------
// Each input transfer is either a timing tick (tuser = 0) or a send request
// (tuser = 1) and yields exactly one result transfer. A request while idle
// builds a FRAME_BYTES-byte frame (address, fan byte, temperature/mode byte,
// each followed by its complement) and starts the header mark; a request
// while busy is dropped and flagged as rejected. Ticks then walk the frame
// REPEATS times: header mark, header space, every bit MSB first as a bit mark
// plus a one- or zero-space, footer mark and gap. The result reports the LED
// envelope level for the coming tick, busy, frame done (on the tick that ends
// the last gap, in tlast) and rejected. On each transfer the segment counter,
// bit counter and rotating frame register update in the accept cycle and
// the result lands in an output register backed by a skid register, so a
// new transfer is taken every cycle while the skid register is empty, and
// one more while a result waits downstream. Segment lengths are latched as
// each segment starts and the address byte at the request; a length of zero
// lasts one tick. Write configuration only while idle.
module ir_climate_frame_transmitter_core import irclim_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int REPEATS     = REPEATS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] power_on, [2:1] mode, [5:3] fan_speed, [13:6] temperature, [15:14] zero
    input  logic [15:0]           s_axis_tdata,
    // [0] opcode: 0 tick, 1 send request
    input  logic                  s_axis_tuser,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] ir_on, [1] busy_res, [2] rejected, [7:3] zero
    output logic [7:0]            m_axis_tdata,
    // frame_done
    output logic                  m_axis_tlast
);

    localparam int TOTAL_BITS = FRAME_BYTES * 8;
    localparam int BITS_W     = $clog2(TOTAL_BITS + 1);
    localparam int REP_W      = $clog2(REPEATS + 1);
    localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(TOTAL_BITS);
    localparam logic [REP_W-1:0]  REP_LAST  = REP_W'(REPEATS - 1);

    // Configuration registers
    logic [7:0] r_hdr_mark, r_hdr_space, r_bit_mark, r_one_space;
    logic [7:0] r_zero_space, r_gap, r_address;

    // Transmit state
    logic [TOTAL_BITS-1:0] r_frame, n_frame;
    logic [4:0]            r_fan_low, n_fan_low;
    logic [2:0]            r_phase, n_phase;
    logic [7:0]            r_count, n_count;
    logic [BITS_W-1:0]     r_bits, n_bits;
    logic [REP_W-1:0]      r_rep, n_rep;

    // Output register and skid register
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    t_frame_req            w_req;
    logic [TOTAL_BITS-1:0] w_new_frame;
    logic [4:0]            w_new_fan_low;
    logic                  w_in_xfer, w_out_xfer;
    logic [7:0]            w_count_dec;
    logic [BITS_W-1:0]     w_bits_dec;
    logic                  w_top_bit;

    assign w_req = '{
        power_on:    s_axis_tdata[0],
        mode:        s_axis_tdata[2:1],
        fan_speed:   s_axis_tdata[5:3],
        temperature: s_axis_tdata[13:6]
    };

    irclim_frame_build #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_build (
        .i_req     (w_req),
        .i_address (r_address),
        .i_fan_low (r_fan_low),
        .o_frame   (w_new_frame),
        .o_fan_low (w_new_fan_low)
    );

    // Hold off input only when both result slots are full
    assign s_axis_tready = !r_skid_valid;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer    = r_out_valid && m_axis_tready;

    assign w_top_bit   = r_frame[TOTAL_BITS-1];
    assign w_count_dec = (r_count != 8'd0) ? r_count - 8'd1 : 8'd0;
    assign w_bits_dec  = (r_bits != '0) ? r_bits - BITS_W'(1) : '0;

    // Next state and result for one transfer
    always_comb begin
        n_frame   = r_frame;
        n_fan_low = r_fan_low;
        n_phase   = r_phase;
        n_count   = r_count;
        n_bits    = r_bits;
        n_rep     = r_rep;
        n_res     = '0;

        if (s_axis_tuser == OP_SEND) begin
            if (r_phase != PH_IDLE) begin
                // drop the request, nothing moves
                n_res.rejected = 1'b1;
            end else begin
                n_frame   = w_new_frame;
                n_fan_low = w_new_fan_low;
                n_phase   = PH_HMARK;
                n_count   = seg_len(r_hdr_mark);
                n_bits    = BITS_FULL;
                n_rep     = '0;
            end
        end else if (r_phase != PH_IDLE) begin
            n_count = w_count_dec;
            if (w_count_dec == 8'd0) begin
                // segment over: advance to the next one
                unique case (r_phase)
                    PH_HMARK: begin
                        n_phase = PH_HSPACE;
                        n_count = seg_len(r_hdr_space);
                    end
                    PH_HSPACE: begin
                        n_phase = PH_BMARK;
                        n_count = seg_len(r_bit_mark);
                    end
                    PH_BMARK: begin
                        n_phase = PH_BSPACE;
                        n_count = seg_len(w_top_bit ? r_one_space : r_zero_space);
                    end
                    PH_BSPACE: begin
                        // rotate so the frame is intact again for the repeat
                        n_frame = {r_frame[TOTAL_BITS-2:0], w_top_bit};
                        n_bits  = w_bits_dec;
                        n_phase = (w_bits_dec != '0) ? PH_BMARK : PH_FMARK;
                        n_count = seg_len(r_bit_mark);
                    end
                    PH_FMARK: begin
                        n_phase = PH_GAP;
                        n_count = seg_len(r_gap);
                    end
                    PH_GAP: begin
                        if (r_rep != REP_LAST) begin
                            n_rep   = r_rep + REP_W'(1);
                            n_phase = PH_HMARK;
                            n_count = seg_len(r_hdr_mark);
                            n_bits  = BITS_FULL;
                        end else begin
                            n_phase          = PH_IDLE;
                            n_count          = 8'd0;
                            n_bits           = '0;
                            n_rep            = '0;
                            n_res.frame_done = 1'b1;
                        end
                    end
                    default: begin
                        n_phase          = PH_IDLE;
                        n_count          = 8'd0;
                        n_bits           = '0;
                        n_rep            = '0;
                        n_res.frame_done = 1'b1;
                    end
                endcase
            end
        end

        n_res.ir_on    = (n_phase == PH_HMARK) || (n_phase == PH_BMARK) ||
                         (n_phase == PH_FMARK);
        n_res.busy_res = (n_phase != PH_IDLE);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mark   <= HDR_MARK_RST;
            r_hdr_space  <= HDR_SPACE_RST;
            r_bit_mark   <= BIT_MARK_RST;
            r_one_space  <= ONE_SPACE_RST;
            r_zero_space <= ZERO_SPC_RST;
            r_gap        <= GAP_RST;
            r_address    <= ADDRESS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_HDR_MARK:  r_hdr_mark   <= i_cfg_wdata;
                REG_HDR_SPACE: r_hdr_space  <= i_cfg_wdata;
                REG_BIT_MARK:  r_bit_mark   <= i_cfg_wdata;
                REG_ONE_SPACE: r_one_space  <= i_cfg_wdata;
                REG_ZERO_SPC:  r_zero_space <= i_cfg_wdata;
                REG_GAP:       r_gap        <= i_cfg_wdata;
                REG_ADDRESS:   r_address    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Transmit state, advanced once per accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame   <= '0;
            r_fan_low <= FAN_LOW_RST;
            r_phase   <= PH_IDLE;
            r_count   <= 8'd0;
            r_bits    <= '0;
            r_rep     <= '0;
        end else if (w_in_xfer) begin
            r_frame   <= n_frame;
            r_fan_low <= n_fan_low;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_bits    <= n_bits;
            r_rep     <= n_rep;
        end
    end

    // Result valid flags: output register first, skid catches a stalled one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_out_xfer) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_in_xfer) begin
                if (r_out_valid && !m_axis_tready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_xfer) begin
                r_out <= r_skid;
            end
        end else if (w_in_xfer) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.rejected, r_out.busy_res, r_out.ir_on};
    assign m_axis_tlast  = r_out.frame_done;

endmodule

/* src/irclim_checker.sv */
// ---------------------------------------------------------------------------
// irclim_checker
// Port-level checks of the IR climate transmitter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module irclim_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A stalled result stays offered and unchanged
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
        "result dropped while stalled")
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "result changed while stalled")

    // The tick that ends the last gap leaves the LED dark and the block idle
    `ASSERT_NEVER(a_done_idle, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast && (m_axis_tdata[0] || m_axis_tdata[1]),
        "frame done while busy or lit")

    // A request is only dropped while a transmission runs
    `ASSERT_NEVER(a_rej_busy, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[2] && !m_axis_tdata[1],
        "rejected while idle")

    // The LED is only driven during a transmission
    `ASSERT_NEVER(a_mark_busy, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[1],
        "mark while idle")

endmodule

bind ir_climate_frame_transmitter_core irclim_checker u_irclim_checker (.*);
